// ===== hw/rtl/clps_pkg.sv =====
// Package for the closed-loop IIR plant simulator.
// Holds payload structs, default widths and register index codes; no dependencies.
package clps_pkg;

    localparam int SIGNAL_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF   = 16;

    // external sample width of target and plant_out (Q16.16)
    localparam int SAMPLE_W    = 32;
    localparam int CFG_INDEX_W = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_NUM_0  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_NUM_1  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_DEN_1  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_DEN_2  = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANT_NUM_1 = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANT_NUM_2 = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANT_DEN_1 = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANT_DEN_2 = 4'd7;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] target;
        logic                       restart;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] plant_out;
        logic                       overflow;
    } t_out_item;

endpackage

// ===== hw/rtl/closed_loop_iir_plant_sim.sv =====
// Closed-loop second-order IIR plant simulator, one shared multiply-accumulate unit.
// The result is registered once the control round completes; no new input is taken
// until it is registered, and a stalled output register holds the run in its last step.
// Steps on the single multiplier/accumulator: 8 products, 2 rounds, 1 error step.
// Reset (synchronous, active low) clears history, coefficients to defaults, handshakes.
// Depends on clps_pkg.
module closed_loop_iir_plant_sim
    import clps_pkg::*;
#(
    parameter int SIGNAL_WIDTH = SIGNAL_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [COEF_WIDTH-1:0]  i_cfg_data
);

    localparam int SW    = SIGNAL_WIDTH;
    localparam int CW    = COEF_WIDTH;
    localparam int CFRAC = CW - 2;
    localparam int PW    = SW + CW;
    localparam int ACC_W = PW + 3;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (CFRAC - 1);
    localparam logic signed [SW-1:0] SIG_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SIG_MIN = {1'b1, {(SW-1){1'b0}}};

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // sequencer steps
    localparam logic [3:0] STEP_P0          = 4'd0;
    localparam logic [3:0] STEP_P1          = 4'd1;
    localparam logic [3:0] STEP_P2          = 4'd2;
    localparam logic [3:0] STEP_P3          = 4'd3;
    localparam logic [3:0] STEP_P_LAST      = 4'd4;
    localparam logic [3:0] STEP_PLANT_ROUND = 4'd5;
    localparam logic [3:0] STEP_ERROR       = 4'd6;
    localparam logic [3:0] STEP_C0          = 4'd7;
    localparam logic [3:0] STEP_C1          = 4'd8;
    localparam logic [3:0] STEP_C2          = 4'd9;
    localparam logic [3:0] STEP_C3          = 4'd10;
    localparam logic [3:0] STEP_C_LAST      = 4'd11;
    localparam logic [3:0] STEP_CTRL_ROUND  = 4'd12;

    logic                 r_state, n_state;
    logic [3:0]           r_cnt, n_cnt;

    logic signed [CW-1:0] r_cn0, r_cn1, r_cd1, r_cd2, r_pn1, r_pn2, r_pd1, r_pd2;

    // plant input history equals controller output history, so one pair serves both
    logic signed [SW-1:0] r_u0, r_u1, r_yh0, r_yh1, r_eprev;
    logic signed [SW-1:0] r_tgt, r_yp, r_err;
    logic signed [PW-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                 r_ovf;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 in_fire, finish;
    logic signed [SW-1:0] tgt_sig;
    logic signed [SW-1:0] mul_a;
    logic signed [CW-1:0] mul_b;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] rs_q;
    logic                 rs_sat;
    logic signed [SW-1:0] rs_val;
    logic signed [SW:0]   err_diff;
    logic                 err_sat;
    logic signed [SW-1:0] err_val;
    logic [SAMPLE_W-1:0]  prev_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign finish      = (r_state == ST_RUN) && (r_cnt == STEP_CTRL_ROUND)
                         && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // target into signal width: clamp when narrower, no overflow flag
    generate
        if (SW >= SAMPLE_W) begin : g_wide
            assign tgt_sig  = SW'(i_in_data.target);
            assign prev_out = r_yh0[SAMPLE_W-1:0];
        end else begin : g_narrow
            logic [SAMPLE_W-SW:0] t_hi;
            assign t_hi     = i_in_data.target[SAMPLE_W-1:SW-1];
            assign tgt_sig  = (&t_hi || ~|t_hi) ? i_in_data.target[SW-1:0] :
                              (i_in_data.target[SAMPLE_W-1] ? SIG_MIN : SIG_MAX);
            assign prev_out = SAMPLE_W'(r_yh0);
        end
    endgenerate

    // operand select for the shared multiplier
    always_comb begin
        mul_a = r_u0;
        mul_b = r_pn1;
        unique case (r_cnt)
            STEP_P0: begin mul_a = r_u0;    mul_b = r_pn1; end
            STEP_P1: begin mul_a = r_u1;    mul_b = r_pn2; end
            STEP_P2: begin mul_a = r_yh0;   mul_b = r_pd1; end
            STEP_P3: begin mul_a = r_yh1;   mul_b = r_pd2; end
            STEP_C0: begin mul_a = r_err;   mul_b = r_cn0; end
            STEP_C1: begin mul_a = r_eprev; mul_b = r_cn1; end
            STEP_C2: begin mul_a = r_u0;    mul_b = r_cd1; end
            STEP_C3: begin mul_a = r_u1;    mul_b = r_cd2; end
            default: begin mul_a = r_u0;    mul_b = r_pn1; end
        endcase
    end

    assign prod_ext = {{(ACC_W-PW){r_prod[PW-1]}}, r_prod};

    // shared round-half-up and saturate
    assign rs_q   = r_acc >>> CFRAC;
    assign rs_sat = !(&rs_q[ACC_W-1:SW-1] || ~|rs_q[ACC_W-1:SW-1]);
    assign rs_val = rs_sat ? (rs_q[ACC_W-1] ? SIG_MIN : SIG_MAX) : rs_q[SW-1:0];

    assign err_diff = {r_tgt[SW-1], r_tgt} - {r_yp[SW-1], r_yp};
    assign err_sat  = (err_diff[SW] != err_diff[SW-1]);
    assign err_val  = err_sat ? (err_diff[SW] ? SIG_MIN : SIG_MAX) : err_diff[SW-1:0];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_RUN;
                    n_cnt   = STEP_P0;
                end
            end
            ST_RUN: begin
                if (r_cnt == STEP_CTRL_ROUND) begin
                    // hold until the output register frees up
                    if (finish) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= STEP_P0;
            r_out_valid <= 1'b0;
            r_cn0       <= CW'(1) << CFRAC;
            r_cn1       <= CW'(1) << CFRAC;
            r_cd1       <= '0;
            r_cd2       <= '0;
            r_pn1       <= CW'(1) << CFRAC;
            r_pn2       <= CW'(1) << CFRAC;
            r_pd1       <= '0;
            r_pd2       <= '0;
            r_u0        <= '0;
            r_u1        <= '0;
            r_yh0       <= '0;
            r_yh1       <= '0;
            r_eprev     <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_CTRL_NUM_0:  r_cn0 <= i_cfg_data;
                    REG_CTRL_NUM_1:  r_cn1 <= i_cfg_data;
                    REG_CTRL_DEN_1:  r_cd1 <= i_cfg_data;
                    REG_CTRL_DEN_2:  r_cd2 <= i_cfg_data;
                    REG_PLANT_NUM_1: r_pn1 <= i_cfg_data;
                    REG_PLANT_NUM_2: r_pn2 <= i_cfg_data;
                    REG_PLANT_DEN_1: r_pd1 <= i_cfg_data;
                    REG_PLANT_DEN_2: r_pd2 <= i_cfg_data;
                    default: ; // drop writes beyond the register list
                endcase
            end

            // a new result loaded in the same cycle keeps valid high
            if (r_out_valid && i_out_ready && !finish) begin
                r_out_valid <= 1'b0;
            end

            if (in_fire) begin
                r_ovf <= 1'b0;
                if (i_in_data.restart) begin
                    r_u0    <= '0;
                    r_u1    <= '0;
                    r_yh0   <= '0;
                    r_yh1   <= '0;
                    r_eprev <= '0;
                end
            end

            if (r_state == ST_RUN) begin
                unique case (r_cnt)
                    STEP_PLANT_ROUND: begin
                        if (rs_sat) begin
                            r_ovf <= 1'b1;
                        end
                    end
                    STEP_ERROR: begin
                        if (err_sat) begin
                            r_ovf <= 1'b1;
                        end
                    end
                    STEP_CTRL_ROUND: begin
                        if (finish) begin
                            r_out_valid        <= 1'b1;
                            r_out.plant_out    <= prev_out;
                            r_out.overflow     <= r_ovf || rs_sat;
                            r_eprev            <= r_err;
                            r_u1               <= r_u0;
                            r_u0               <= rs_val;
                            r_yh1              <= r_yh0;
                            r_yh0              <= r_yp;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_tgt <= tgt_sig;
        end
        r_prod <= mul_a * mul_b;
        if (r_state == ST_RUN) begin
            unique case (r_cnt)
                STEP_P0, STEP_C0:          r_acc <= RND_HALF;
                STEP_P1, STEP_P2,
                STEP_C1, STEP_C2:          r_acc <= r_acc + prod_ext;
                // denominator terms subtract
                STEP_P3, STEP_P_LAST,
                STEP_C3, STEP_C_LAST:      r_acc <= r_acc - prod_ext;
                STEP_PLANT_ROUND:          r_yp  <= rs_val;
                STEP_ERROR:                r_err <= err_val;
                default: ;
            endcase
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for closed_loop_iir_plant_sim: random and directed setpoint streams
// checked against an in-bench fixed-point loop predictor, under bursty input and output stalls.
// Depends on clps_pkg and the closed_loop_iir_plant_sim RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import clps_pkg::*;

    localparam int  CFRAC        = COEF_WIDTH_DEF - 2;
    localparam longint SIG_MAX   = 64'sd2147483647;
    localparam longint SIG_MIN   = -64'sd2147483648;
    localparam int  LONG_HOLD    = 400;
    localparam int  DRAIN_CYCLES = 30;
    localparam int  MAX_REPORTS  = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    t_in_item                  in_data = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    t_out_item                 out_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [COEF_WIDTH_DEF-1:0] cfg_data = '0;

    closed_loop_iir_plant_sim dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // loop predictor state
    logic signed [COEF_WIDTH_DEF-1:0] coef [8];
    longint plant_y [2];
    longint drive_u [2];   // controller output, which is also the plant input
    longint ctrl_c [2];
    longint err_last;
    logic   step_ovf;

    t_out_item expected_samples [$];
    int        mismatch_count = 0;

    // stimulus pacing
    int burst_left = 0;
    int max_gap = 0;
    int stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    function automatic longint sat_signal(input longint v);
        if (v > SIG_MAX) begin
            step_ovf = 1'b1;
            return SIG_MAX;
        end
        if (v < SIG_MIN) begin
            step_ovf = 1'b1;
            return SIG_MIN;
        end
        return v;
    endfunction

    // exact four-tap sum, round half up to signal scale, saturate
    function automatic longint mac4(input longint s0, s1, s2, s3, c0, c1, c2, c3);
        longint acc;
        acc = s0 * c0 + s1 * c1 + s2 * c2 + s3 * c3;
        acc = (acc + (64'sd1 <<< (CFRAC - 1))) >>> CFRAC;
        return sat_signal(acc);
    endfunction

    function automatic void clear_loop_history();
        plant_y  = '{0, 0};
        drive_u  = '{0, 0};
        ctrl_c   = '{0, 0};
        err_last = 0;
    endfunction

    function automatic t_out_item loop_step(input t_in_item item);
        longint    tgt, yp, err, u, prev;
        t_out_item res;
        if (item.restart)
            clear_loop_history();
        step_ovf = 1'b0;
        tgt = longint'($signed(item.target));
        yp = mac4(drive_u[0], drive_u[1], plant_y[0], plant_y[1],
                  longint'(coef[REG_PLANT_NUM_1]), longint'(coef[REG_PLANT_NUM_2]),
                  -longint'(coef[REG_PLANT_DEN_1]), -longint'(coef[REG_PLANT_DEN_2]));
        err = sat_signal(tgt - yp);
        u = mac4(err, err_last, ctrl_c[0], ctrl_c[1],
                 longint'(coef[REG_CTRL_NUM_0]), longint'(coef[REG_CTRL_NUM_1]),
                 -longint'(coef[REG_CTRL_DEN_1]), -longint'(coef[REG_CTRL_DEN_2]));
        err_last = err;
        ctrl_c[1] = ctrl_c[0];
        ctrl_c[0] = u;
        drive_u[1] = drive_u[0];
        drive_u[0] = u;
        prev = plant_y[0];
        plant_y[1] = plant_y[0];
        plant_y[0] = yp;
        res.plant_out = prev[31:0];
        res.overflow = step_ovf;
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_samples.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: plant_out %0d overflow %0b",
                             out_data.plant_out, out_data.overflow);
            end else begin
                want = expected_samples.pop_front();
                if (out_data.plant_out !== want.plant_out ||
                    out_data.overflow !== want.overflow) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: plant_out exp %0d got %0d, overflow exp %0b got %0b",
                                 want.plant_out, out_data.plant_out,
                                 want.overflow, out_data.overflow);
                end
            end
        end
    end

    // receiver: short random stalls, plus a long hold on request
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            out_ready <= 1'b0;
            hold_left = $urandom_range(12);
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic signed [31:0] tgt, input logic restart);
        t_in_item item;
        item.target = tgt;
        item.restart = restart;
        if (max_gap > 0 && burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, max_gap)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge i_clk); while (!in_ready);
        expected_samples.push_back(loop_step(item));
    endtask

    // drop valid right after the last transaction, then let the block go idle
    task automatic finish_phase();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_coef(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [COEF_WIDTH_DEF-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        if (idx <= REG_PLANT_DEN_2)
            coef[idx] = val;
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all_coefs(input logic [COEF_WIDTH_DEF-1:0] val);
        for (int r = REG_CTRL_NUM_0; r <= REG_PLANT_DEN_2; r++)
            write_coef(CFG_INDEX_W'(r), val);
    endtask

    function automatic logic signed [31:0] rand_target();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $signed(32'($urandom_range(32'h0010_0000))) - 32'sh0008_0000;
        if (pick < 90)
            return $urandom;
        case ($urandom_range(4))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return -32'sh1;
            default: return 32'sh1;
        endcase
    endfunction

    function automatic logic [COEF_WIDTH_DEF-1:0] rand_coef(input int mode);
        case (mode)
            0: return COEF_WIDTH_DEF'($urandom_range(16383)) - 16'd8192;
            1: return COEF_WIDTH_DEF'($urandom);
            default: begin
                case ($urandom_range(4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'h4000;
                    default: return 16'hC000;
                endcase
            end
        endcase
    endfunction

    task automatic test_default_coefs();
        max_gap = 0;
        stall_pct = 0;
        send_sample(32'sh0000_0000, 1'b1);
        send_sample(32'sh0001_0000, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(-32'sh1, 1'b0);
        send_sample(32'sh1, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh0000_0000, 1'b0);
        finish_phase();
    endtask

    task automatic test_coef_extremes();
        write_all_coefs(16'h7FFF);
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh0001_0000, 1'b0);
        finish_phase();
        write_all_coefs(16'h8000);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(-32'sh0001_0000, 1'b0);
        finish_phase();
        // out-of-range indexes must leave the coefficients alone
        write_coef(REG_PLANT_DEN_2 + 1'b1, 16'hA5A5);
        write_coef('1, 16'h5A5A);
        send_sample(32'sh0002_0000, 1'b0);
        send_sample(32'sh0000_0000, 1'b1);
        finish_phase();
    endtask

    task automatic test_rounding_ties();
        write_all_coefs(16'h0000);
        write_coef(REG_CTRL_NUM_0, 16'h0001);
        write_coef(REG_PLANT_NUM_1, 16'h4000);
        send_sample(32'sh0000_2000, 1'b1);
        send_sample(-32'sh0000_2000, 1'b0);
        send_sample(32'sh0000_6000, 1'b0);
        send_sample(-32'sh0000_6000, 1'b0);
        send_sample(32'sh0000_A000, 1'b0);
        finish_phase();
    endtask

    task automatic test_random_loops();
        for (int phase = 0; phase < 6; phase++) begin
            for (int r = REG_CTRL_NUM_0; r <= REG_PLANT_DEN_2; r++)
                write_coef(CFG_INDEX_W'(r), rand_coef(phase % 3));
            max_gap = (phase % 3 == 0) ? 0 : 20;
            stall_pct = (phase % 2 == 0) ? 0 : 25;
            for (int n = 0; n < 200; n++)
                send_sample(rand_target(), $urandom_range(99) < 3);
            finish_phase();
        end
    endtask

    task automatic test_output_backpressure();
        write_coef(REG_CTRL_NUM_0, 16'h2000);
        write_coef(REG_CTRL_NUM_1, 16'h1000);
        write_coef(REG_PLANT_DEN_1, 16'hE000);
        max_gap = 0;
        stall_pct = 0;
        hold_reqs++;
        for (int n = 0; n < 60; n++)
            send_sample(rand_target(), n == 0);
        finish_phase();
    endtask

    initial begin
        coef[REG_CTRL_NUM_0]  = 16'h4000;
        coef[REG_CTRL_NUM_1]  = 16'h4000;
        coef[REG_CTRL_DEN_1]  = 16'h0000;
        coef[REG_CTRL_DEN_2]  = 16'h0000;
        coef[REG_PLANT_NUM_1] = 16'h4000;
        coef[REG_PLANT_NUM_2] = 16'h4000;
        coef[REG_PLANT_DEN_1] = 16'h0000;
        coef[REG_PLANT_DEN_2] = 16'h0000;
        clear_loop_history();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_coefs();
        test_coef_extremes();
        test_rounding_ties();
        test_random_loops();
        test_output_backpressure();

        if (mismatch_count == 0)
            $display("closed_loop_iir_plant_sim regression: pass");
        else
            $display("closed_loop_iir_plant_sim regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("closed_loop_iir_plant_sim regression: fail");
        $finish;
    end

endmodule
